/* rtl/bbs_pkg.sv */
// ----------------------------------------------------------------------------
// bbs_pkg
// shared types and constants of the binomial band smoother
// ----------------------------------------------------------------------------
package bbs_pkg;

  localparam int MAX_BANDS_DEF = 128;

  localparam int LEVEL_W = 17;            // clamped level, 0..65536
  localparam int IN_W    = 18;            // signed q2.16 input level
  localparam int WIN_LEN = 9;
  localparam int RAD_W   = 3;

  localparam logic [LEVEL_W-1:0] UNIT_LEVEL = 17'd65536;

  // kernel radius codes
  localparam logic [RAD_W-1:0] RAD_PASS = 3'd0;
  localparam logic [RAD_W-1:0] RAD_FIVE = 3'd2;
  localparam logic [RAD_W-1:0] RAD_NINE = 3'd4;

  // smoothing level codes
  localparam logic [1:0] SMOOTH_PASS = 2'd0;
  localparam logic [1:0] SMOOTH_FIVE = 2'd1;

  // register indexes
  localparam logic CFG_SMOOTH_LEVEL   = 1'b0;
  localparam logic CFG_REFERENCE_MODE = 1'b1;

  typedef logic [LEVEL_W-1:0] level_t;

  // one pending result travelling from the window stage to the kernel stage
  typedef struct packed {
    logic             valid;
    logic             frame_end;
    logic [RAD_W-1:0] radius;
  } tok_t;

endpackage

/* rtl/binomial_band_smoother_unit.sv */
// ----------------------------------------------------------------------------
// binomial_band_smoother_unit
// frame-wise binomial smoothing of spectrum band levels
// ----------------------------------------------------------------------------
// Band levels arrive at up to one word per cycle, signed q2.16, and are clamped to
// 0..65536 (65536 is 1.0). With smoothing level 0 or reference mode the
// clamped level goes straight out; level 1 applies the 1,4,6,4,1 / 16 kernel
// and level 2 (or 3) the 1,8,28,56,70,56,28,8,1 / 256 kernel, rounded half up,
// with the first and last band repeated past the frame edges. The kernel is
// chosen at the first band of each frame, so register writes land at the next
// frame. Results lag the input by the kernel radius (0, 2 or 4 bands); the
// band marked tlast flushes the pending results and the final one carries
// tlast (none does in pass-through if the tlast band is past MAX_BANDS). Bands
// past MAX_BANDS are dropped. Throughput is one band per cycle unless the
// output stalls; after tlast the input is held off while the flush drains
// through the same window. Path: window register, weighted sum, output register.
// ----------------------------------------------------------------------------
module binomial_band_smoother_unit
  import bbs_pkg::*;
#(
  parameter int MAX_BANDS = MAX_BANDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,       // 0 smooth_level, 1 reference_mode
  input  logic [1:0]  cfg_data,
  // input band stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // [17:0] band_level, rest zero
  input  logic        s_axis_tlast,    // last_band
  // smoothed output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,    // [16:0] smoothed_level, rest zero
  output logic        m_axis_tlast     // frame_end
);

  logic [1:0] smooth_level;
  logic       reference_mode;
  tok_t       tok;
  level_t     win [WIN_LEN];
  logic       tok_take;
  level_t     out_level;

  // register file, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_level   <= SMOOTH_FIVE;
      reference_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SMOOTH_LEVEL:   smooth_level   <= cfg_data;
        CFG_REFERENCE_MODE: reference_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // window update, frame bookkeeping and edge flush
  bbs_window #(
    .MAX_BANDS (MAX_BANDS)
  ) u_window (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_level       (s_axis_tdata[IN_W-1:0]),
    .in_last        (s_axis_tlast),
    .smooth_level   (smooth_level),
    .reference_mode (reference_mode),
    .tok_take       (tok_take),
    .tok            (tok),
    .win            (win)
  );

  // weighted sum and output word register
  bbs_kernel u_kernel (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok),
    .win       (win),
    .tok_take  (tok_take),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_level (out_level),
    .out_end   (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, out_level};

endmodule

/* rtl/bbs_window.sv */
// ----------------------------------------------------------------------------
// bbs_window
// clamps incoming levels, keeps the tap window and frame counters, and
// sequences the edge flush after the last band
// ----------------------------------------------------------------------------
module bbs_window
  import bbs_pkg::*;
#(
  parameter int MAX_BANDS = MAX_BANDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IN_W-1:0]   in_level,
  input  logic              in_last,
  input  logic [1:0]        smooth_level,
  input  logic              reference_mode,
  input  logic              tok_take,
  output tok_t              tok,
  output level_t            win [WIN_LEN]
);

  localparam int BS_RAW = $clog2(MAX_BANDS + 1);
  localparam int BS_W   = (BS_RAW < 3) ? 3 : BS_RAW;
  localparam logic [BS_W-1:0] MAXB = BS_W'(MAX_BANDS);
  // right-edge index of a frame cut at the band limit, saturated at the largest radius
  localparam logic [RAD_W-1:0] IDX_SAT = (MAX_BANDS - 1 > 4) ? RAD_W'(4) : RAD_W'(MAX_BANDS - 1);

  logic [BS_W-1:0]  bands_seen, bands_seen_next;
  logic [RAD_W-1:0] radius, radius_next;
  logic [RAD_W-1:0] flush_k, flush_k_next;
  logic [RAD_W-1:0] flush_base, flush_base_next;
  level_t           win_next [WIN_LEN];
  level_t           v;
  logic [RAD_W-1:0] cfg_radius;
  logic [RAD_W-1:0] base;
  logic             flushing, advance, in_fire, fl_fire;
  logic             emit, emit_end;

  assign flushing = (flush_k != '0);
  assign advance  = !tok.valid || tok_take;
  assign in_ready = advance && !flushing;
  assign in_fire  = in_valid && in_ready;
  assign fl_fire  = flushing && advance;

  always_comb begin
    if (in_level[IN_W-1]) begin
      v = '0;
    end else if (in_level[IN_W-2:0] > UNIT_LEVEL) begin
      v = UNIT_LEVEL;
    end else begin
      v = in_level[LEVEL_W-1:0];
    end
  end

  always_comb begin
    if (reference_mode || smooth_level == SMOOTH_PASS) begin
      cfg_radius = RAD_PASS;
    end else if (smooth_level == SMOOTH_FIVE) begin
      cfg_radius = RAD_FIVE;
    end else begin
      cfg_radius = RAD_NINE;
    end
  end

  always_comb begin
    win_next        = win;
    bands_seen_next = bands_seen;
    radius_next     = radius;
    flush_k_next    = flush_k;
    flush_base_next = flush_base;
    emit            = 1'b0;
    emit_end        = 1'b0;
    base            = IDX_SAT;
    if (in_fire) begin
      if (bands_seen < MAXB) begin
        if (bands_seen == '0) begin
          radius_next = cfg_radius;
          for (int i = 0; i < WIN_LEN; i++) win_next[i] = v;
        end else begin
          for (int i = 0; i < WIN_LEN - 1; i++) win_next[i] = win[i + 1];
          win_next[WIN_LEN-1] = v;
        end
        bands_seen_next = bands_seen + 1'b1;
        emit     = (bands_seen >= BS_W'(radius_next));
        emit_end = in_last && (radius_next == RAD_PASS);
        base     = (bands_seen > BS_W'(4)) ? RAD_W'(4) : bands_seen[RAD_W-1:0];
      end
      if (in_last) begin
        bands_seen_next = '0;
        if (radius_next != RAD_PASS) begin
          flush_k_next    = RAD_W'(1);
          flush_base_next = base;
        end
      end
    end else if (fl_fire) begin
      // repeat the last band past the right edge
      for (int i = 0; i < WIN_LEN - 1; i++) win_next[i] = win[i + 1];
      win_next[WIN_LEN-1] = win[WIN_LEN-1];
      emit     = ({1'b0, flush_k} + {1'b0, flush_base}) >= {1'b0, radius};
      emit_end = (flush_k == radius);
      flush_k_next = (flush_k == radius) ? '0 : flush_k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
    flush_base <= flush_base_next;
    if (rst) begin
      bands_seen <= '0;
      radius     <= RAD_PASS;
      flush_k    <= '0;
      tok        <= '0;
    end else begin
      bands_seen <= bands_seen_next;
      radius     <= radius_next;
      flush_k    <= flush_k_next;
      if (advance) begin
        tok.valid     <= emit;
        tok.frame_end <= emit_end;
        tok.radius    <= radius_next;
      end
    end
  end

endmodule

/* rtl/bbs_kernel.sv */
// ----------------------------------------------------------------------------
// bbs_kernel
// binomial weighted sum over the tap window and the result register
// ----------------------------------------------------------------------------
module bbs_kernel
  import bbs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  tok_t   tok,
  input  level_t win [WIN_LEN],
  output logic   tok_take,
  output logic   out_valid,
  input  logic   out_ready,
  output level_t out_level,
  output logic   out_end
);

  logic [17:0] p0, p1, p2, p3;
  logic [25:0] sum9;
  logic [20:0] sum5;
  level_t      filt;

  // symmetric kernels: fold the pairs first
  assign p0 = {1'b0, win[0]} + {1'b0, win[8]};
  assign p1 = {1'b0, win[1]} + {1'b0, win[7]};
  assign p2 = {1'b0, win[2]} + {1'b0, win[6]};
  assign p3 = {1'b0, win[3]} + {1'b0, win[5]};

  assign sum9 = 26'(p0) + (26'(p1) << 3) + 26'(p2) * 26'd28 + 26'(p3) * 26'd56
              + 26'(win[4]) * 26'd70 + 26'd128;
  assign sum5 = 21'(win[4]) + 21'(win[8]) + ((21'(win[5]) + 21'(win[7])) << 2)
              + 21'(win[6]) * 21'd6 + 21'd8;

  always_comb begin
    case (tok.radius)
      RAD_PASS: filt = win[WIN_LEN-1];
      RAD_FIVE: filt = sum5[20:4];
      default:  filt = sum9[24:8];
    endcase
  end

  assign tok_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tok_take) begin
      out_valid <= tok.valid;
    end
    if (tok_take && tok.valid) begin
      out_level <= filt;
      out_end   <= tok.frame_end;
    end
  end

endmodule

/* verif/tb_binomial_band_smoother_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binomial_band_smoother_unit
// self-checking stream test of the binomial band smoother
// ----------------------------------------------------------------------------
// A queue of band words, filled frame by frame, feeds a clocked driver that
// sends in random bursts. Every accepted word goes through an in-bench model
// of the smoother, which queues the smoothed words it owes. A clocked monitor
// checks each output word against the oldest queued one. The run steps
// through every smoothing level and reference mode, with a directed opening,
// random frames, two frames past the band limit, a long receiver hold-off and
// register writes that fall between and inside frames.
// ----------------------------------------------------------------------------
module tb_binomial_band_smoother_unit;
  import bbs_pkg::*;

  localparam int N_BANDS      = MAX_BANDS_DEF;
  localparam int DRAIN_CYCLES = 16;      // pipeline is two deep, leave margin
  localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
  localparam int LIMIT_CYCLES = 200000;
  localparam int N_PHASES     = 10;

  // smoothing level codes not named in the package
  localparam logic [1:0] SMOOTH_NINE     = 2'd2;
  localparam logic [1:0] SMOOTH_NINE_ALT = 2'd3;   // behaves as nine-tap

  // receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_pattern_t;

  typedef struct packed {
    logic [IN_W-1:0] level;
    logic            last;
  } band_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               frame_end;
  } smooth_word_t;

  // ---- dut signals, inputs known from time zero
  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic        cfg_index     = 1'b0;
  logic [1:0]  cfg_data      = 2'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;     // [17:0] band_level, rest zero
  logic        s_axis_tlast  = 1'b0;   // last_band
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [16:0] smoothed_level, rest zero
  logic        m_axis_tlast;           // frame_end

  // ---- bench state
  band_word_t   band_q[$];       // words waiting to be sent
  smooth_word_t smoothed_q[$];   // smoothed words owed by the block
  int           mismatches = 0;
  int           cycle_cnt  = 0;

  // sender burst shaping
  int burst_left = 0;
  int gap_left   = 0;

  // receiver pattern and hold-off request
  rx_pattern_t rx_mode    = RX_OPEN;
  int          mode_left  = 0;
  int          rx_tick    = 0;
  int          hold_left  = 0;
  int          hold_req   = 0;   // bumped by the stimulus
  int          hold_seen  = 0;   // owned by the receiver

  // ---- model state
  logic [LEVEL_W-1:0] win [WIN_LEN];   // oldest first, newest in the top slot
  int unsigned        seen      = 0;   // bands taken in the current frame
  logic [RAD_W-1:0]   frame_rad = RAD_PASS;
  logic [1:0]         mdl_smooth = SMOOTH_FIVE;
  logic               mdl_ref    = 1'b0;

  always #10 clk = ~clk;

  binomial_band_smoother_unit #(
    .MAX_BANDS(N_BANDS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // ---- smoothing model

  function automatic void shift_window(input logic [LEVEL_W-1:0] v);
    for (int i = 0; i < WIN_LEN - 1; i++) win[i] = win[i + 1];
    win[WIN_LEN - 1] = v;
  endfunction

  // weighted sum over the window for the latched radius, rounded half up
  function automatic logic [LEVEL_W-1:0] kernel_sum();
    logic [31:0] acc;
    if (frame_rad == RAD_PASS) return win[8];
    if (frame_rad == RAD_FIVE) begin
      acc = win[4] + 4 * win[5] + 6 * win[6] + 4 * win[7] + win[8];
      return LEVEL_W'((acc + 8) >> 4);
    end
    acc = win[0] + 8 * win[1] + 28 * win[2] + 56 * win[3] + 70 * win[4]
        + 56 * win[5] + 28 * win[6] + 8 * win[7] + win[8];
    return LEVEL_W'((acc + 128) >> 8);
  endfunction

  // queues every smoothed word that one accepted band word brings out
  task automatic smooth_band(input logic [IN_W-1:0] raw, input logic last);
    logic [LEVEL_W-1:0] lvl;
    int unsigned        idx;
    int unsigned        k;
    // clamp q2.16 to 0..1.0
    if (raw[IN_W-1])                 lvl = '0;
    else if (raw[16:0] > UNIT_LEVEL) lvl = UNIT_LEVEL;
    else                             lvl = raw[16:0];

    if (seen < N_BANDS) begin
      if (seen == 0) begin
        // kernel picked at the first band, window primed with it
        if (mdl_ref || mdl_smooth == SMOOTH_PASS) frame_rad = RAD_PASS;
        else if (mdl_smooth == SMOOTH_FIVE)       frame_rad = RAD_FIVE;
        else                                      frame_rad = RAD_NINE;
        for (int i = 0; i < WIN_LEN; i++) win[i] = lvl;
      end else begin
        shift_window(lvl);
      end
      idx = seen;
      seen++;
      if (idx >= frame_rad)
        smoothed_q.push_back('{level: kernel_sum(),
                               frame_end: (last && frame_rad == RAD_PASS)});
    end else begin
      // past the band limit: dropped, only a last band still matters
      if (!last) return;
      idx = N_BANDS - 1;
    end

    if (last) begin
      // flush with the last kept band repeated as right edge
      for (k = 1; k <= frame_rad; k++) begin
        shift_window(win[WIN_LEN - 1]);
        if (idx + k >= frame_rad)
          smoothed_q.push_back('{level: kernel_sum(), frame_end: (k == frame_rad)});
      end
      seen = 0;
    end
  endtask

  // ---- stimulus helpers

  function automatic logic [IN_W-1:0] rand_level();
    case ($urandom_range(0, 9))
      0: return IN_W'($urandom);
      1: begin
        case ($urandom_range(0, 6))
          0:       return 18'd0;
          1:       return 18'd65535;
          2:       return 18'd65536;
          3:       return 18'd65537;
          4:       return 18'h20000;    // most negative
          5:       return 18'h1FFFF;    // most positive
          default: return 18'h3FFFF;    // minus one lsb
        endcase
      end
      default: return IN_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // one frame of random levels; closed frames end with last set
  task automatic queue_frame(input int len, input bit closed);
    for (int i = 0; i < len; i++)
      band_q.push_back('{level: rand_level(), last: (closed && i == len - 1)});
  endtask

  // waits on the falling edge so the queues and valid are settled
  task automatic wait_idle();
    do @(negedge clk);
    while (band_q.size() != 0 || s_axis_tvalid || smoothed_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SMOOTH_LEVEL) mdl_smooth = val;
    else                         mdl_ref    = val[0];
  endtask

  // both registers written while the block is quiet
  task automatic set_mode(input logic [1:0] smooth, input logic ref_on);
    wait_idle();
    write_reg(CFG_SMOOTH_LEVEL, smooth);
    write_reg(CFG_REFERENCE_MODE, {1'b0, ref_on});
    @(negedge clk);
  endtask

  // ---- driver: one word per handshake, random bursts and gaps
  always @(posedge clk) begin : drive_bands
    band_word_t w;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        smooth_band(s_axis_tdata[IN_W-1:0], s_axis_tlast);
      // offer the next word only once the current one is gone
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (band_q.size() != 0) begin
          w = band_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(24 - IN_W){1'b0}}, w.level};
          s_axis_tlast  <= w.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---- receiver: changing stall patterns, plus the long hold-off on request
  always @(posedge clk) begin : drive_ready
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_pattern_t'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 80);
      end else begin
        mode_left--;
      end
      rx_tick++;
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= (rx_tick % 4 == 0);
        default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // ---- monitor: every output word against the oldest owed one

  task automatic flag_mismatch(input string what, input smooth_word_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected level %0d end %0b, got data 0x%06h end %0b",
               what, want.level, want.frame_end, m_axis_tdata, m_axis_tlast);
  endtask

  always @(posedge clk) begin : check_words
    smooth_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (smoothed_q.size() == 0) begin
        flag_mismatch("unexpected word", '0);
      end else begin
        want = smoothed_q.pop_front();
        if (m_axis_tdata !== {{(24 - LEVEL_W){1'b0}}, want.level} ||
            m_axis_tlast !== want.frame_end)
          flag_mismatch("wrong word", want);
      end
    end
  end

  // ---- watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("binomial_band_smoother_unit test failed");
      $finish;
    end
  end

  // ---- stimulus
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: clamp extremes on the five-tap kernel, short frames
    set_mode(SMOOTH_FIVE, 1'b0);
    band_q.push_back('{level: 18'h20000, last: 1'b0});   // most negative
    band_q.push_back('{level: 18'h1FFFF, last: 1'b0});   // most positive
    band_q.push_back('{level: 18'd65536, last: 1'b0});   // exactly 1.0
    band_q.push_back('{level: 18'd65537, last: 1'b0});   // just above 1.0
    band_q.push_back('{level: 18'd0,     last: 1'b1});
    band_q.push_back('{level: 18'd65535, last: 1'b1});   // single band frame
    band_q.push_back('{level: 18'd1,     last: 1'b0});
    band_q.push_back('{level: 18'd32768, last: 1'b1});   // two band frame

    // nine-tap with frames shorter than the kernel
    set_mode(SMOOTH_NINE, 1'b0);
    band_q.push_back('{level: 18'h3FFFF, last: 1'b0});
    band_q.push_back('{level: 18'd65536, last: 1'b0});
    band_q.push_back('{level: 18'd12345, last: 1'b1});
    band_q.push_back('{level: 18'd40000, last: 1'b1});

    // level three acts as nine-tap
    set_mode(SMOOTH_NINE_ALT, 1'b0);
    queue_frame(4, 1'b1);

    // pass-through
    set_mode(SMOOTH_PASS, 1'b0);
    queue_frame(3, 1'b1);

    // reference mode overrides the nine-tap setting
    set_mode(SMOOTH_NINE, 1'b1);
    queue_frame(2, 1'b1);

    // random phases; a phase may end inside a frame, so the next register
    // write lands mid-frame and must wait for the following first band
    for (int p = 0; p < N_PHASES; p++) begin
      set_mode(2'(p % 4), (p % 5 == 4));
      if (p == 2) begin
        // receiver holds off while the sender keeps pushing
        hold_req++;
        // nine-tap frame past the band limit, last band dropped
        queue_frame(N_BANDS + 3, 1'b1);
      end
      if (p == 8) queue_frame(N_BANDS + 1, 1'b1);   // same in pass-through
      for (int n = 0; n < 20; ) begin
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        queue_frame(len, (n + len < 20) || ($urandom_range(0, 2) != 0));
        n += len;
      end
    end

    wait_idle();
    if (mismatches == 0 && smoothed_q.size() == 0) begin
      $display("binomial_band_smoother_unit test passed");
    end else begin
      $display("binomial_band_smoother_unit test failed");
    end
    $finish;
  end

endmodule
